FILE: sv/bbd_pkg.sv
package bbd_pkg;

  localparam int unsigned PERIOD_MAX = 16;
  localparam int unsigned SQ         = 5;
  localparam int unsigned KEY_LEN    = SQ * SQ;
  localparam int unsigned LW         = 5;
  localparam int unsigned PW         = 5;
  localparam int unsigned KW         = 60;
  localparam int unsigned CFG_W      = 2;
  localparam int unsigned CRD_W      = 3;
  localparam int unsigned ADDR_W     = $clog2(2 * PERIOD_MAX);
  localparam int unsigned CNT_W      = $clog2(PERIOD_MAX + 1);
  localparam int unsigned IDX_W      = (PERIOD_MAX > 1) ? $clog2(PERIOD_MAX) : 1;

  typedef enum logic [CFG_W-1:0] {
    CFG_PERIOD,
    CFG_KEY_A,
    CFG_KEY_B,
    CFG_KEY_C
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WCOL,
    ST_RDROW,
    ST_RDCOL,
    ST_CALC,
    ST_WAIT
  } state_e;

  typedef logic [KEY_LEN*LW-1:0] key_t;

  typedef struct packed {
    logic             found;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
  } loc_t;

  function automatic logic [LW-1:0] key_entry(key_t key, logic [LW-1:0] idx);
    logic [LW-1:0] res;
    if (idx >= LW'(KEY_LEN - 1)) begin
      res = key[KEY_LEN*LW-1 -: LW];
    end else begin
      res = key[idx*LW +: LW];
    end
    return res;
  endfunction

  // lowest matching position wins
  function automatic loc_t find_letter(key_t key, logic [LW-1:0] letter);
    loc_t res;
    res = '0;
    for (int r = SQ - 1; r >= 0; r--) begin
      for (int c = SQ - 1; c >= 0; c--) begin
        if (key[(r*SQ+c)*LW +: LW] == letter) begin
          res.found = 1'b1;
          res.row   = CRD_W'(r);
          res.col   = CRD_W'(c);
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: sv/bifid_block_decipher_unit.sv
// channel   direction  signals
// ---------------------------------------------------------------------------
// config    in         cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// letter    in         in_valid_i, in_ready_o, letter_i, restart_i
// plain     out        out_valid_o, out_ready_i, plain_letter_o, last_o, bad_letter_o
//
// a letter writes its row, then its column, to the coordinate memory over its
// single write port. a completed block then bursts period results, each via
// ST_RDROW, ST_RDCOL, ST_CALC and ST_WAIT: two reads of the coordinate memory,
// the key lookup and the output handshake. no letter is taken during the burst.
// reset clears the control and config registers only; the coordinate memory is never cleared.
// a stalled output holds its result until out_ready_i.
module bifid_block_decipher_unit
  import bbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_index_i,
  input  logic [KW-1:0]    cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [LW-1:0]    letter_i,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LW-1:0]    plain_letter_o,
  output logic             last_o,
  output logic             bad_letter_o
);

  logic [CRD_W-1:0] mem_q [2*PERIOD_MAX];

  state_e            state_q, state_d;
  logic [PW-1:0]     period_q;
  logic [KW-1:0]     key_a_q, key_b_q;
  logic [LW-1:0]     key_c_q;
  logic [CNT_W-1:0]  held_q;
  logic              err_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ADDR_W-1:0] waddr_q;
  logic [CRD_W-1:0]  col_q;
  logic [CRD_W-1:0]  row_q;
  logic [CRD_W-1:0]  rd_data_q;
  logic              out_valid_q;
  logic [LW-1:0]     out_letter_q;
  logic              out_last_q;
  logic              out_bad_q;

  key_t              key_w;
  logic [CNT_W-1:0]  p_eff;
  logic [CNT_W-1:0]  held_eff;
  logic [CNT_W-1:0]  held_inc;
  loc_t              loc;
  logic              in_req;
  logic              out_req;
  logic              is_last;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CRD_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  assign key_w       = {key_c_q, key_b_q, key_a_q};
  assign cfg_ready_o = 1'b1;
  assign in_req      = in_valid_i && in_ready_o;
  assign out_req     = out_valid_q && out_ready_i;
  assign loc         = find_letter(key_w, letter_i);
  assign held_inc    = CNT_W'(held_q + 1'b1);
  assign is_last     = (CNT_W'(idx_q) == CNT_W'(p_eff - 1'b1));

  always_comb begin
    if (period_q == '0) begin
      p_eff = CNT_W'(1);
    end else if (period_q > PW'(PERIOD_MAX)) begin
      p_eff = CNT_W'(PERIOD_MAX);
    end else begin
      p_eff = CNT_W'(period_q);
    end
  end

  assign held_eff = (restart_i || held_q >= p_eff) ? '0 : held_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          state_d = ST_WCOL;
        end
      end
      ST_WCOL: begin
        state_d = (held_inc == p_eff) ? ST_RDROW : ST_IDLE;
      end
      ST_RDROW: state_d = ST_RDCOL;
      ST_RDCOL: state_d = ST_CALC;
      ST_CALC:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (out_req) begin
          state_d = is_last ? ST_IDLE : ST_RDROW;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = waddr_q;
    mem_wdata  = col_q;
    mem_raddr  = ADDR_W'(idx_q);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_we     = in_valid_i;
        mem_waddr  = ADDR_W'({held_eff, 1'b0});
        mem_wdata  = loc.row;
      end
      ST_WCOL: begin
        mem_we    = 1'b1;
        mem_waddr = {waddr_q[ADDR_W-1:1], 1'b1};
      end
      ST_RDROW: mem_raddr = ADDR_W'(idx_q);
      ST_RDCOL: mem_raddr = ADDR_W'(p_eff + idx_q);
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // coordinate memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PW'(5);
      key_a_q  <= '0;
      key_b_q  <= '0;
      key_c_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PERIOD: period_q <= cfg_data_i[PW-1:0];
        CFG_KEY_A:  key_a_q  <= cfg_data_i;
        CFG_KEY_B:  key_b_q  <= cfg_data_i;
        CFG_KEY_C:  key_c_q  <= cfg_data_i[LW-1:0];
        default: begin
          key_c_q <= key_c_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      err_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_req) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            held_q <= held_eff;
            err_q  <= ((restart_i || held_q >= p_eff) ? 1'b0 : err_q) | ~loc.found;
          end
        end
        ST_WCOL: begin
          held_q <= held_inc;
          idx_q  <= '0;
        end
        ST_CALC: out_valid_q <= 1'b1;
        ST_WAIT: begin
          if (out_req) begin
            if (is_last) begin
              held_q <= '0;
              err_q  <= 1'b0;
            end else begin
              idx_q <= IDX_W'(idx_q + 1'b1);
            end
          end
        end
        default: begin
          idx_q <= idx_q;
        end
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_req) begin
      waddr_q <= ADDR_W'({held_eff, 1'b0});
      col_q   <= loc.col;
    end
    if (state_q == ST_RDCOL) begin
      row_q <= rd_data_q;
    end
    if (state_q == ST_CALC) begin
      out_letter_q <= key_entry(key_w, LW'(SQ * row_q + rd_data_q));
      out_last_q   <= is_last;
      out_bad_q    <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign plain_letter_o = out_letter_q;
  assign last_o         = out_last_q;
  assign bad_letter_o   = out_bad_q;

endmodule
